@@ rtl/b64e_pkg.sv @@
// ----------------------------------------------------------------------------
// b64e_pkg
// shared types, constants and the character table for the base64 encoder
// ----------------------------------------------------------------------------
package b64e_pkg;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam logic [6:0] PAD_CHAR = 7'h3D;

    // number of real bytes in a finished group
    localparam logic [1:0] GRP_ONE   = 2'd1;
    localparam logic [1:0] GRP_TWO   = 2'd2;
    localparam logic [1:0] GRP_THREE = 2'd3;

    typedef struct packed {
        logic [23:0] triple;
        logic [1:0]  count;
        logic        last;
    } group_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // standard alphabet: A-Z, a-z, 0-9, '+', '/'
    function automatic logic [6:0] sextet_char(input logic [5:0] v);
        logic [7:0] s;
        begin
            s = 8'd0;
            case (v) inside
                [6'd0:6'd25]:  s = 8'(v) + 8'd65;
                [6'd26:6'd51]: s = 8'(v) + 8'd71;
                [6'd52:6'd61]: s = 8'(v) - 8'd4;
                6'd62:         s = 8'd43;
                default:       s = 8'd47;
            endcase
            return s[6:0];
        end
    endfunction

endpackage

@@ rtl/b64e_front.sv @@
// ----------------------------------------------------------------------------
// b64e_front
// collects input bytes into groups of up to three and queues finished groups
// ----------------------------------------------------------------------------
module b64e_front
    import b64e_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    output logic       byte_stall,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    input  logic       q_full,
    output logic       q_push,
    output group_t     q_data
);

    localparam logic [1:0] POS_EMPTY = 2'd0;
    localparam logic [1:0] POS_ONE   = 2'd1;
    localparam logic [1:0] POS_TWO   = 2'd2;

    logic [15:0] held_reg;
    logic [15:0] held_next;
    logic [1:0]  pos_reg;
    logic [1:0]  pos_next;
    logic        accept;

    assign byte_stall = q_full;
    assign accept     = byte_valid && !byte_stall;

    always_comb
    begin
        held_next     = held_reg;
        pos_next      = pos_reg;
        q_push        = 1'b0;
        q_data.triple = {held_reg, data_byte};
        q_data.count  = GRP_THREE;
        q_data.last   = last_byte;
        case (pos_reg)
            POS_ONE:
            begin
                q_data.triple = {held_reg[15:8], data_byte, 8'h00};
                q_data.count  = GRP_TWO;
                if (accept)
                begin
                    if (last_byte)
                    begin
                        q_push   = 1'b1;
                        pos_next = POS_EMPTY;
                    end
                    else
                    begin
                        held_next = {held_reg[15:8], data_byte};
                        pos_next  = POS_TWO;
                    end
                end
            end
            POS_TWO:
            begin
                if (accept)
                begin
                    q_push   = 1'b1;
                    pos_next = POS_EMPTY;
                end
            end
            default:
            begin
                // unused position behaves like an empty group
                q_data.triple = {data_byte, 16'h0000};
                q_data.count  = GRP_ONE;
                if (accept)
                begin
                    if (last_byte)
                    begin
                        q_push   = 1'b1;
                        pos_next = POS_EMPTY;
                    end
                    else
                    begin
                        held_next = {data_byte, 8'h00};
                        pos_next  = POS_ONE;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= 16'h0000;
            pos_reg  <= POS_EMPTY;
        end
        else
        begin
            held_reg <= held_next;
            pos_reg  <= pos_next;
        end
    end

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg != 2'd3)
        else $error("group position out of range");

    a_push_ends_group: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |=> pos_reg == POS_EMPTY)
        else $error("group not closed after push");

    a_last_pushes: assert property (@(posedge clk) disable iff (!rst_n)
        accept && last_byte |-> q_push)
        else $error("final byte did not close a group");

endmodule

@@ rtl/b64e_queue.sv @@
// ----------------------------------------------------------------------------
// b64e_queue
// short queue of finished groups between the byte side and the char side
// ----------------------------------------------------------------------------
module b64e_queue
    import b64e_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  group_t    wr_data,
    input  logic      pop,
    output group_t    rd_data,
    output q_status_t status
);

    group_t               mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg;
    logic [Q_PTR_W-1:0]   rd_ptr_reg;
    logic [Q_CNT_W-1:0]   cnt_reg;
    logic [Q_CNT_W-1:0]   cnt_next;

    assign status.full  = cnt_reg == Q_CNT_W'(Q_DEPTH);
    assign status.empty = cnt_reg == '0;
    assign rd_data      = mem[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            cnt_reg <= cnt_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !status.full)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !status.empty)
        else $error("pop from empty queue");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= Q_CNT_W'(Q_DEPTH))
        else $error("queue count out of range");

endmodule

@@ rtl/b64e_back.sv @@
// ----------------------------------------------------------------------------
// b64e_back
// turns each queued group into four characters, one per cycle while char_stall is low
// ----------------------------------------------------------------------------
module b64e_back
    import b64e_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  group_t     q_data,
    input  q_status_t  q_status,
    output logic       q_pop,
    output logic       char_valid,
    input  logic       char_stall,
    output logic [6:0] out_char,
    output logic       last_char
);

    localparam logic [1:0] SLOT_HI   = 2'd0;
    localparam logic [1:0] SLOT_MID  = 2'd1;
    localparam logic [1:0] SLOT_LO   = 2'd2;
    localparam logic [1:0] SLOT_LAST = 2'd3;

    logic [1:0] slot_reg;
    logic       valid_reg;
    logic [6:0] char_reg;
    logic       last_reg;
    logic       load;
    logic [6:0] char_next;

    // output register refills whenever the queue holds a group and the register is empty or being taken
    assign load  = !q_status.empty && (!valid_reg || !char_stall);
    assign q_pop = load && (slot_reg == SLOT_LAST);

    always_comb
    begin
        case (slot_reg)
            SLOT_HI:
                char_next = sextet_char(q_data.triple[23:18]);
            SLOT_MID:
                char_next = sextet_char(q_data.triple[17:12]);
            SLOT_LO:
                char_next = (q_data.count == GRP_ONE) ? PAD_CHAR
                                                      : sextet_char(q_data.triple[11:6]);
            default:
                char_next = (q_data.count == GRP_THREE) ? sextet_char(q_data.triple[5:0])
                                                        : PAD_CHAR;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg  <= SLOT_HI;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                slot_reg  <= slot_reg + 1'b1;
                valid_reg <= 1'b1;
            end
            else if (!char_stall)
                valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            char_reg <= char_next;
            last_reg <= q_data.last && (slot_reg == SLOT_LAST);
        end
    end

    assign char_valid = valid_reg;
    assign out_char   = char_reg;
    assign last_char  = last_reg;

    a_pop_on_last_slot: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> slot_reg == SLOT_HI)
        else $error("slot not reset after group");

    a_load_has_data: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> valid_reg)
        else $error("loaded char not presented");

    a_last_after_slot: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(valid_reg) && last_reg |-> slot_reg == SLOT_HI)
        else $error("last char flag off its group end");

endmodule

@@ rtl/base64_stream_encoder.sv @@
// ----------------------------------------------------------------------------
// base64_stream_encoder
// byte stream in, standard base64 characters with padding out
// ----------------------------------------------------------------------------
//  channel  | signals                          | words
//  ---------+----------------------------------+------------------------------
//  byte in  | byte_valid byte_stall data_byte  | one raw byte, last_byte marks
//           | last_byte                        | the end of the message
//  char out | char_valid char_stall out_char   | one ascii char, last_char on
//           | last_char                        | the final char of a message
//
//  a byte is taken every cycle while the group queue has room; a group of
//  three bytes yields four chars, one per cycle from the char side while
//  char_stall is low. after its closing byte, a group is written into a
//  queue entry and its first char then into the output register. reset
//  clears group position, queue and output valid. byte_stall rises only
//  when both queue entries hold pending groups.
// ----------------------------------------------------------------------------
module base64_stream_encoder
    import b64e_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    output logic       byte_stall,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    output logic       char_valid,
    input  logic       char_stall,
    output logic [6:0] out_char,
    output logic       last_char
);

    logic      q_push;
    logic      q_pop;
    group_t    q_wr_data;
    group_t    q_rd_data;
    q_status_t q_status;

    b64e_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .data_byte  (data_byte),
        .last_byte  (last_byte),
        .q_full     (q_status.full),
        .q_push     (q_push),
        .q_data     (q_wr_data)
    );

    b64e_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_data (q_wr_data),
        .pop     (q_pop),
        .rd_data (q_rd_data),
        .status  (q_status)
    );

    b64e_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_data     (q_rd_data),
        .q_status   (q_status),
        .q_pop      (q_pop),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .out_char   (out_char),
        .last_char  (last_char)
    );

endmodule
